// File: design/ott_pkg.sv
`default_nettype none

package ott_pkg;

    localparam int OTT_MAX_SAMPLES = 1024;
    localparam int OTT_BINS        = 100;
    localparam int OTT_SAMPLE_BITS = 16;

    // Products taken through the shared multiplier during the scan and for the final threshold.
    localparam logic [2:0] MUL_OP_A = 3'd0;
    localparam logic [2:0] MUL_OP_B = 3'd1;
    localparam logic [2:0] MUL_OP_D = 3'd2;
    localparam logic [2:0] MUL_OP_N = 3'd3;
    localparam logic [2:0] MUL_OP_L = 3'd4;
    localparam logic [2:0] MUL_OP_R = 3'd5;
    localparam logic [2:0] MUL_OP_Q = 3'd6;

    typedef struct packed {
        logic       load;
        logic       idx_clr;
        logic       idx_inc;
        logic       st_rd;
        logic       hist_div;
        logic       bin_clr_wr;
        logic       bin_rd_hist;
        logic       bin_wr_hist;
        logic       bin_rd_scan;
        logic       scan_init;
        logic       scan_acc;
        logic       mul_start;
        logic       mul_capture;
        logic [2:0] mul_op;
        logic       cmp_update;
        logic       emit_flat;
        logic       emit_thr;
    } ott_cmd_t;

    typedef struct packed {
        logic flat;
        logic clr_end;
        logic hist_end;
        logic scan_end;
        logic div_done;
        logic mul_done;
        logic n1_zero;
        logic n2_zero;
        logic have;
    } ott_sts_t;

endpackage

`default_nettype wire

// File: design/ott_ram.sv
`default_nettype none

module ott_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// File: design/ott_div.sv
`default_nettype none

module ott_div #(
    parameter int NW = 23,
    parameter int DW = 16,
    localparam int CNTW = $clog2(NW + 1)
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [NW-1:0] n,
    input  wire logic [DW-1:0] d,
    output logic               done,
    output logic      [NW-1:0] q
);

    logic [DW-1:0]   rem_reg;
    logic [NW-1:0]   quo_reg;
    logic [DW-1:0]   d_reg;
    logic [CNTW-1:0] cnt_reg;
    logic            run_reg;
    logic            done_reg;
    logic [DW:0]     rem_sh;
    logic [DW:0]     diff;
    logic            ge;

    // One quotient bit per cycle, restoring form.
    assign rem_sh = {rem_reg, quo_reg[NW-1]};
    assign ge     = rem_sh >= {1'b0, d_reg};
    assign diff   = rem_sh - {1'b0, d_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= CNTW'(NW);
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNTW'(1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= n;
            d_reg   <= d;
        end
        else if (run_reg)
        begin
            rem_reg <= ge ? diff[DW-1:0] : rem_sh[DW-1:0];
            quo_reg <= {quo_reg[NW-2:0], ge};
        end
    end

    assign done = done_reg;
    assign q    = quo_reg;

endmodule

`default_nettype wire

// File: design/ott_mul.sv
`default_nettype none

module ott_mul #(
    parameter int AW = 74,
    parameter int BW = 37,
    parameter int PW = 96,
    localparam int CNTW = $clog2(BW + 1)
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [AW-1:0] a,
    input  wire logic [BW-1:0] b,
    output logic               done,
    output logic      [PW-1:0] p
);

    logic [PW-1:0]   a_reg;
    logic [BW-1:0]   b_reg;
    logic [PW-1:0]   acc_reg;
    logic [CNTW-1:0] cnt_reg;
    logic            run_reg;
    logic            done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= CNTW'(BW);
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNTW'(1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Shift and add, one multiplier bit per cycle.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= PW'(a);
            b_reg   <= b;
            acc_reg <= '0;
        end
        else if (run_reg)
        begin
            if (b_reg[0])
            begin
                acc_reg <= acc_reg + a_reg;
            end
            a_reg <= a_reg << 1;
            b_reg <= b_reg >> 1;
        end
    end

    assign done = done_reg;
    assign p    = acc_reg;

endmodule

`default_nettype wire

// File: design/ott_ctrl.sv
`default_nettype none

module ott_ctrl
    import ott_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    input  wire logic     last,
    input  wire ott_sts_t sts,
    output logic          busy,
    output ott_cmd_t      cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_CHECK  = 4'd1;
    localparam logic [3:0] S_CLR    = 4'd2;
    localparam logic [3:0] S_HRD    = 4'd3;
    localparam logic [3:0] S_HX     = 4'd4;
    localparam logic [3:0] S_HDIV   = 4'd5;
    localparam logic [3:0] S_HBIN   = 4'd6;
    localparam logic [3:0] S_SRD    = 4'd7;
    localparam logic [3:0] S_SBW    = 4'd8;
    localparam logic [3:0] S_MSTART = 4'd9;
    localparam logic [3:0] S_MWAIT  = 4'd10;
    localparam logic [3:0] S_CMP    = 4'd11;
    localparam logic [3:0] S_FIN    = 4'd12;
    localparam logic [3:0] S_FDIV   = 4'd13;
    localparam logic [3:0] S_FWAIT  = 4'd14;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic [2:0] op_reg;
    logic [2:0] op_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg    <= MUL_OP_A;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        cmd.mul_op = op_reg;
        state_next = state_reg;
        op_next    = op_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    if (last)
                    begin
                        state_next = S_CHECK;
                    end
                end
            end
            S_CHECK:
            begin
                if (sts.flat)
                begin
                    cmd.emit_flat = 1'b1;
                    state_next    = S_IDLE;
                end
                else
                begin
                    cmd.idx_clr = 1'b1;
                    state_next  = S_CLR;
                end
            end
            S_CLR:
            begin
                cmd.bin_clr_wr = 1'b1;
                if (sts.clr_end)
                begin
                    cmd.idx_clr = 1'b1;
                    state_next  = S_HRD;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                end
            end
            S_HRD:
            begin
                if (sts.hist_end)
                begin
                    cmd.scan_init = 1'b1;
                    cmd.idx_clr   = 1'b1;
                    state_next    = S_SRD;
                end
                else
                begin
                    cmd.st_rd  = 1'b1;
                    state_next = S_HX;
                end
            end
            S_HX:
            begin
                cmd.hist_div = 1'b1;
                state_next   = S_HDIV;
            end
            S_HDIV:
            begin
                if (sts.div_done)
                begin
                    cmd.bin_rd_hist = 1'b1;
                    state_next      = S_HBIN;
                end
            end
            S_HBIN:
            begin
                cmd.bin_wr_hist = 1'b1;
                cmd.idx_inc     = 1'b1;
                state_next      = S_HRD;
            end
            S_SRD:
            begin
                if (sts.scan_end)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.bin_rd_scan = 1'b1;
                    state_next      = S_SBW;
                end
            end
            S_SBW:
            begin
                cmd.scan_acc = 1'b1;
                if (sts.n1_zero)
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_SRD;
                end
                else if (sts.n2_zero)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    op_next    = MUL_OP_A;
                    state_next = S_MSTART;
                end
            end
            S_MSTART:
            begin
                cmd.mul_start = 1'b1;
                state_next    = S_MWAIT;
            end
            S_MWAIT:
            begin
                if (sts.mul_done)
                begin
                    cmd.mul_capture = 1'b1;
                    state_next      = S_MSTART;
                    case (op_reg)
                        MUL_OP_A: op_next = MUL_OP_B;
                        MUL_OP_B: op_next = MUL_OP_D;
                        MUL_OP_D: op_next = MUL_OP_N;
                        MUL_OP_N: op_next = MUL_OP_L;
                        MUL_OP_L: op_next = MUL_OP_R;
                        default:  state_next = S_CMP;
                    endcase
                end
            end
            S_CMP:
            begin
                cmd.cmp_update = 1'b1;
                cmd.idx_inc    = 1'b1;
                state_next     = S_SRD;
            end
            S_FIN:
            begin
                if (sts.have)
                begin
                    op_next    = MUL_OP_Q;
                    state_next = S_FDIV;
                end
                else
                begin
                    cmd.emit_thr = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_FDIV:
            begin
                cmd.mul_start = 1'b1;
                state_next    = S_FWAIT;
            end
            S_FWAIT:
            begin
                if (sts.mul_done)
                begin
                    cmd.emit_thr = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = state_reg != S_IDLE;

endmodule

`default_nettype wire

// File: design/ott_dp.sv
`default_nettype none

module ott_dp
    import ott_pkg::*;
#(
    parameter int MAX_SAMPLES = OTT_MAX_SAMPLES,
    parameter int BINS        = OTT_BINS,
    parameter int SAMPLE_BITS = OTT_SAMPLE_BITS
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire ott_cmd_t               cmd,
    input  wire logic [SAMPLE_BITS-1:0] sample,
    output ott_sts_t                    sts,
    output logic                        done,
    output logic      [SAMPLE_BITS-1:0] threshold,
    output logic                        flat_range
);

    localparam int S     = SAMPLE_BITS;
    localparam int SAW   = $clog2(MAX_SAMPLES);
    localparam int CW    = $clog2(MAX_SAMPLES + 1);
    localparam int SUMW  = S + SAW;
    localparam int BIW   = $clog2(BINS);
    localparam int BCW   = $clog2(BINS + 1);
    localparam int IW    = (CW > BCW) ? CW : BCW;
    localparam int PW1   = SUMW + CW;
    localparam int NUMW  = 2 * PW1;
    localparam int DENW  = 2 * CW;
    localparam int LW    = NUMW + DENW;
    localparam int DDW   = S + BIW;
    localparam int DVW   = (S > BCW) ? S : BCW;
    localparam int BINW  = CW + SUMW;

    // The threshold quotient bin * range / BINS is taken as a multiply by a
    // rounded-up reciprocal; the shift covers every DDW-bit dividend exactly.
    localparam int          THR_K     = DDW + BIW;
    localparam logic [63:0] THR_RECIP = ((64'd1 << THR_K) + 64'(BINS) - 64'd1) / 64'(BINS);

    logic [CW-1:0]   count_reg;
    logic [S-1:0]    min_reg;
    logic [S-1:0]    max_reg;
    logic [SUMW-1:0] total_reg;
    logic [IW-1:0]   idx_reg;
    logic [CW-1:0]   n1_reg;
    logic [CW-1:0]   n2_reg;
    logic [SUMW-1:0] s1_reg;
    logic [PW1-1:0]  a_reg;
    logic [PW1-1:0]  b_reg;
    logic [NUMW-1:0] num_reg;
    logic [DENW-1:0] den_reg;
    logic [LW-1:0]   l_reg;
    logic [NUMW-1:0] bnum_reg;
    logic [DENW-1:0] bden_reg;
    logic [BIW-1:0]  best_reg;
    logic            have_reg;
    logic            done_reg;
    logic [S-1:0]    thr_reg;
    logic            flat_reg;

    logic [S-1:0]    range;
    logic [S-1:0]    x;
    logic [BINW-1:0] bin_rdata;
    logic [CW-1:0]   bin_cnt;
    logic [SUMW-1:0] bin_sum;
    logic [CW-1:0]   n1_sum;
    logic [SUMW-1:0] s2;
    logic [PW1-1:0]  diff;
    logic            store_ok;

    logic            div_start;
    logic [DDW-1:0]  div_n;
    logic [DVW-1:0]  div_d;
    logic            div_done;
    logic [DDW-1:0]  div_q;
    logic [BIW-1:0]  hist_bin;

    logic [NUMW-1:0] mul_a;
    logic [PW1-1:0]  mul_b;
    logic            mul_done;
    logic [LW-1:0]   mul_p;

    logic            bin_wr_en;
    logic [BIW-1:0]  bin_wr_addr;
    logic [BINW-1:0] bin_wr_data;
    logic            bin_rd_en;
    logic [BIW-1:0]  bin_rd_addr;
    logic            better;

    assign range     = max_reg - min_reg;
    assign store_ok  = count_reg < CW'(MAX_SAMPLES);
    assign bin_cnt   = bin_rdata[BINW-1:SUMW];
    assign bin_sum   = bin_rdata[SUMW-1:0];
    assign n1_sum    = n1_reg + bin_cnt;
    assign s2        = total_reg - s1_reg;
    assign diff      = (a_reg >= b_reg) ? (a_reg - b_reg) : (b_reg - a_reg);
    assign hist_bin  = (div_q >= DDW'(BINS)) ? BIW'(BINS - 1) : div_q[BIW-1:0];
    assign better    = !have_reg || (l_reg > mul_p);

    ott_ram #(
        .WIDTH(S),
        .DEPTH(MAX_SAMPLES)
    ) u_store (
        .clk    (clk),
        .wr_en  (cmd.load && store_ok),
        .wr_addr(count_reg[SAW-1:0]),
        .wr_data(sample),
        .rd_en  (cmd.st_rd),
        .rd_addr(idx_reg[SAW-1:0]),
        .rd_data(x)
    );

    assign bin_wr_en   = cmd.bin_clr_wr || cmd.bin_wr_hist;
    assign bin_wr_addr = cmd.bin_clr_wr ? idx_reg[BIW-1:0] : hist_bin;
    assign bin_wr_data = cmd.bin_clr_wr ? '0
                       : {bin_cnt + CW'(1), bin_sum + SUMW'(x)};
    assign bin_rd_en   = cmd.bin_rd_hist || cmd.bin_rd_scan;
    assign bin_rd_addr = cmd.bin_rd_hist ? hist_bin : idx_reg[BIW-1:0];

    ott_ram #(
        .WIDTH(BINW),
        .DEPTH(BINS)
    ) u_bins (
        .clk    (clk),
        .wr_en  (bin_wr_en),
        .wr_addr(bin_wr_addr),
        .wr_data(bin_wr_data),
        .rd_en  (bin_rd_en),
        .rd_addr(bin_rd_addr),
        .rd_data(bin_rdata)
    );

    assign div_start = cmd.hist_div;
    assign div_n     = DDW'(x - min_reg) * DDW'(BINS);
    assign div_d     = DVW'(range);

    ott_div #(
        .NW(DDW),
        .DW(DVW)
    ) u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .start(div_start),
        .n    (div_n),
        .d    (div_d),
        .done (div_done),
        .q    (div_q)
    );

    always_comb
    begin
        case (cmd.mul_op)
            MUL_OP_A:
            begin
                mul_a = NUMW'(s1_reg);
                mul_b = PW1'(n2_reg);
            end
            MUL_OP_B:
            begin
                mul_a = NUMW'(s2);
                mul_b = PW1'(n1_reg);
            end
            MUL_OP_D:
            begin
                mul_a = NUMW'(diff);
                mul_b = diff;
            end
            MUL_OP_N:
            begin
                mul_a = NUMW'(n1_reg);
                mul_b = PW1'(n2_reg);
            end
            MUL_OP_L:
            begin
                mul_a = num_reg;
                mul_b = PW1'(bden_reg);
            end
            MUL_OP_Q:
            begin
                mul_a = NUMW'(THR_RECIP);
                mul_b = PW1'(DDW'(best_reg) * DDW'(range));
            end
            default:
            begin
                mul_a = bnum_reg;
                mul_b = PW1'(den_reg);
            end
        endcase
    end

    ott_mul #(
        .AW(NUMW),
        .BW(PW1),
        .PW(LW)
    ) u_mul (
        .clk  (clk),
        .rst_n(rst_n),
        .start(cmd.mul_start),
        .a    (mul_a),
        .b    (mul_b),
        .done (mul_done),
        .p    (mul_p)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            min_reg   <= '1;
            max_reg   <= '0;
            total_reg <= '0;
            idx_reg   <= '0;
            have_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.emit_flat || cmd.emit_thr;
            if (cmd.load && store_ok)
            begin
                count_reg <= count_reg + CW'(1);
                total_reg <= total_reg + SUMW'(sample);
                if (sample < min_reg)
                begin
                    min_reg <= sample;
                end
                if (sample > max_reg)
                begin
                    max_reg <= sample;
                end
            end
            if (cmd.emit_flat || cmd.emit_thr)
            begin
                count_reg <= '0;
                min_reg   <= '1;
                max_reg   <= '0;
                total_reg <= '0;
            end
            if (cmd.idx_clr)
            begin
                idx_reg <= '0;
            end
            else if (cmd.idx_inc)
            begin
                idx_reg <= idx_reg + IW'(1);
            end
            if (cmd.scan_init)
            begin
                have_reg <= 1'b0;
            end
            else if (cmd.cmp_update && better)
            begin
                have_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan_init)
        begin
            n1_reg   <= '0;
            s1_reg   <= '0;
            best_reg <= '0;
        end
        if (cmd.scan_acc)
        begin
            n1_reg <= n1_sum;
            n2_reg <= count_reg - n1_sum;
            s1_reg <= s1_reg + bin_sum;
        end
        if (cmd.mul_capture)
        begin
            case (cmd.mul_op)
                MUL_OP_A: a_reg   <= mul_p[PW1-1:0];
                MUL_OP_B: b_reg   <= mul_p[PW1-1:0];
                MUL_OP_D: num_reg <= mul_p[NUMW-1:0];
                MUL_OP_N: den_reg <= mul_p[DENW-1:0];
                MUL_OP_L: l_reg   <= mul_p;
                default:  ;
            endcase
        end
        if (cmd.cmp_update && better)
        begin
            best_reg <= idx_reg[BIW-1:0];
            bnum_reg <= num_reg;
            bden_reg <= den_reg;
        end
        if (cmd.emit_flat)
        begin
            thr_reg  <= min_reg;
            flat_reg <= 1'b1;
        end
        else if (cmd.emit_thr)
        begin
            thr_reg  <= have_reg ? (min_reg + mul_p[THR_K +: S])
                                 : (min_reg + (range >> 1));
            flat_reg <= 1'b0;
        end
    end

    assign sts.flat     = range == '0;
    assign sts.clr_end  = idx_reg == IW'(BINS - 1);
    assign sts.hist_end = idx_reg == IW'(count_reg);
    assign sts.scan_end = idx_reg == IW'(BINS);
    assign sts.div_done = div_done;
    assign sts.mul_done = mul_done;
    assign sts.n1_zero  = n1_sum == '0;
    assign sts.n2_zero  = n1_sum == count_reg;
    assign sts.have     = have_reg;

    assign done       = done_reg;
    assign threshold  = thr_reg;
    assign flat_range = flat_reg;

endmodule

`default_nettype wire

// File: design/otsu_histogram_threshold.sv
// Samples are taken one per cycle while busy is low; the beat carrying last
// ends the set and raises busy until the result is out. A set whose samples
// are all equal is answered from its range check with flat_range set.
// Otherwise the block clears the histogram memory, runs each stored sample
// through the shared restoring divider that picks its bin, takes up to BINS
// times six passes of the shift-add multiplier for the variance scan, and,
// when a best bin was found, one more multiplier pass for the threshold. The
// result beat is shown on threshold and flat_range for exactly one cycle
// while done is high and cannot be stalled; busy drops in that same cycle.
`default_nettype none

module otsu_histogram_threshold
    import ott_pkg::*;
#(
    parameter int MAX_SAMPLES = OTT_MAX_SAMPLES,
    parameter int BINS        = OTT_BINS,
    parameter int SAMPLE_BITS = OTT_SAMPLE_BITS
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    output logic                        busy,
    input  wire logic [SAMPLE_BITS-1:0] sample,
    input  wire logic                   last,
    output logic                        done,
    output logic      [SAMPLE_BITS-1:0] threshold,
    output logic                        flat_range
);

    ott_cmd_t cmd;
    ott_sts_t sts;

    ott_ctrl u_ctrl (
        .clk  (clk),
        .rst_n(rst_n),
        .start(start),
        .last (last),
        .sts  (sts),
        .busy (busy),
        .cmd  (cmd)
    );

    ott_dp #(
        .MAX_SAMPLES(MAX_SAMPLES),
        .BINS       (BINS),
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sample    (sample),
        .sts       (sts),
        .done      (done),
        .threshold (threshold),
        .flat_range(flat_range)
    );

endmodule

`default_nettype wire

// File: bench/otsu_histogram_threshold_tb.sv
`default_nettype none

module otsu_histogram_threshold_tb;
    import ott_pkg::*;

    typedef struct {
        logic [15:0] thr;
        logic        flat;
    } otsu_result_t;

    class otsu_scoreboard;
        logic [15:0]  store [OTT_MAX_SAMPLES];
        int           count;
        logic [15:0]  vmin;
        logic [15:0]  vmax;
        longint       vsum;
        otsu_result_t pending_q[$];
        int           errors;

        function new();
            errors = 0;
            clear_set();
        endfunction

        function void clear_set();
            count = 0;
            vmin = 16'hffff;
            vmax = 16'h0000;
            vsum = 0;
        endfunction

        function void predict_threshold();
            otsu_result_t res;
            longint       rng;
            longint       bcnt [OTT_BINS];
            longint       bsum [OTT_BINS];
            longint       id;
            longint       n1, n2, s1, s2, best;
            logic [255:0] a, b, d, num, den, l, r, bnum, bden;
            bit           have;
            rng = vmax - vmin;
            res.flat = 1'b0;
            if (rng == 0) begin
                res.thr = vmin;
                res.flat = 1'b1;
            end else begin
                for (int i = 0; i < OTT_BINS; i++) begin
                    bcnt[i] = 0;
                    bsum[i] = 0;
                end
                for (int i = 0; i < count; i++) begin
                    id = ((longint'(store[i]) - vmin) * OTT_BINS) / rng;
                    if (id >= OTT_BINS) id = OTT_BINS - 1;
                    bcnt[id]++;
                    bsum[id] += store[i];
                end
                n1 = 0;
                s1 = 0;
                best = 0;
                have = 0;
                bnum = '0;
                bden = 256'd1;
                for (int i = 0; i < OTT_BINS; i++) begin
                    n1 += bcnt[i];
                    if (n1 == 0) continue;
                    n2 = count - n1;
                    if (n2 == 0) break;
                    s1 += bsum[i];
                    s2 = vsum - s1;
                    a = 256'(s1) * 256'(n2);
                    b = 256'(s2) * 256'(n1);
                    d = (a >= b) ? a - b : b - a;
                    num = d * d;
                    den = 256'(n1) * 256'(n2);
                    l = num * bden;
                    r = bnum * den;
                    if (!have || l > r) begin
                        have = 1;
                        best = i;
                        bnum = num;
                        bden = den;
                    end
                end
                if (have) res.thr = 16'(vmin + (best * rng) / OTT_BINS);
                else res.thr = 16'(vmin + rng / 2);
            end
            pending_q = {pending_q, res};
            clear_set();
        endfunction

        function void note_beat(logic [15:0] v, logic l);
            if (count < OTT_MAX_SAMPLES) begin
                store[count] = v;
                count++;
                if (v < vmin) vmin = v;
                if (v > vmax) vmax = v;
                vsum += v;
            end
            if (l) predict_threshold();
        endfunction

        function void check_result(logic [15:0] thr, logic flat);
            otsu_result_t e;
            if (pending_q.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: threshold=%0d flat_range=%0b", thr, flat);
                return;
            end
            e = pending_q.pop_front();
            if (thr !== e.thr || flat !== e.flat) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: threshold exp=%0d act=%0d flat_range exp=%0b act=%0b",
                             e.thr, thr, e.flat, flat);
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic [15:0] sample = '0;
    logic        last = 1'b0;
    logic        busy;
    logic        done;
    logic [15:0] threshold;
    logic        flat_range;

    otsu_scoreboard sb = new();
    bit             quiet = 0;
    int             beats_sent = 0;

    otsu_histogram_threshold dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .sample     (sample),
        .last       (last),
        .done       (done),
        .threshold  (threshold),
        .flat_range (flat_range)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && done) sb.check_result(threshold, flat_range);
    end

    task automatic send_beat(input logic [15:0] v, input logic l);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 12);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        sample <= v;
        last <= l;
        do @(posedge clk); while (busy);
        sb.note_beat(v, l);
        beats_sent++;
    endtask

    task automatic send_set(input int len, input logic [15:0] lo, input logic [15:0] hi);
        logic [15:0] v;
        for (int i = 0; i < len; i++)
        begin
            v = 16'($urandom_range(lo, hi));
            send_beat(v, i == len - 1);
        end
    endtask

    initial
    begin
        int          len;
        int          kind;
        logic [15:0] lo, hi, t;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_beat(16'h0000, 1'b1);
        send_beat(16'hffff, 1'b0);
        send_beat(16'hffff, 1'b1);
        send_beat(16'h0000, 1'b0);
        send_beat(16'hffff, 1'b1);
        send_beat(16'h1234, 1'b0);
        send_beat(16'h1235, 1'b1);
        send_beat(16'h0100, 1'b0);
        send_beat(16'h0100, 1'b0);
        send_beat(16'h0100, 1'b0);
        send_beat(16'h8000, 1'b1);
        send_beat(16'haaaa, 1'b0);
        send_beat(16'h5555, 1'b0);
        send_beat(16'h7fff, 1'b1);
        // Overfill the store; last arrives on a beat that is dropped.
        send_set(OTT_MAX_SAMPLES + 6, 16'h0000, 16'hffff);

        while (beats_sent < 2000)
        begin
            quiet = ($urandom_range(0, 5) == 0);
            len = ($urandom_range(0, 40) == 0) ? $urandom_range(900, 1100)
                                               : $urandom_range(1, 40);
            kind = $urandom_range(0, 3);
            lo = 16'($urandom());
            hi = 16'($urandom());
            if (lo > hi)
            begin
                t = lo;
                lo = hi;
                hi = t;
            end
            case (kind)
                0: send_set($urandom_range(1, 8), lo, lo);
                1: send_set(len, lo, (lo > 16'hffc0) ? 16'hffff : lo + 16'($urandom_range(1, 63)));
                2: send_set(len, lo, hi);
                default: send_set(len, 16'h0000, 16'hffff);
            endcase
        end
        start <= 1'b0;
        last <= 1'b0;

        while (sb.pending_q.size() > 0) @(posedge clk);
        repeat (200) @(posedge clk);
        if (sb.errors == 0 && sb.pending_q.size() == 0)
            $display("** otsu_histogram_threshold: PASSED **");
        else
            $display("** otsu_histogram_threshold: FAILED **");
        $finish;
    end

    initial
    begin
        #(64'd2_000_000_000);
        $display("** otsu_histogram_threshold: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire
